### sv/mras_pkg.sv
`timescale 1ns / 1ps

package mras_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 66;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int ANGLE_W   = 16;
    localparam int MAG_W     = 17;
    localparam int PC_W      = 7;

    localparam logic [31:0] SAMPLE_PERIOD_DEF = 32'd429497;
    localparam int          SINE_BITS_DEF     = 10;
    localparam logic [31:0] INV_TWO_PI_Q32    = 32'd683565276;
    localparam logic [63:0] TWO_PI_Q30        = 64'd6746518852;
    localparam logic [63:0] ONE_Q30           = 64'd1073741824;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_RS   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LD   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LQ   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ILD  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ILQ  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FLUX = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KP   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_KI   = 3'd7;

    localparam logic [CFG_W-1:0] KP_RESET = 31'd65536;
    localparam logic [CFG_W-1:0] KI_RESET = 31'd6554;

    // Micro-operations
    localparam logic [3:0] OP_JCLR = 4'd0;
    localparam logic [3:0] OP_SIN  = 4'd1;
    localparam logic [3:0] OP_COS  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_MULT = 4'd4;
    localparam logic [3:0] OP_WB   = 4'd5;
    localparam logic [3:0] OP_ADD  = 4'd6;
    localparam logic [3:0] OP_SUB  = 4'd7;
    localparam logic [3:0] OP_ANG  = 4'd8;
    localparam logic [3:0] OP_CLR  = 4'd9;
    localparam logic [3:0] OP_END  = 4'd10;

    // Operand and destination codes
    localparam logic [4:0] S_ZERO  = 5'd0;
    localparam logic [4:0] S_X     = 5'd1;
    localparam logic [4:0] S_Y     = 5'd2;
    localparam logic [4:0] S_UD    = 5'd3;
    localparam logic [4:0] S_UQ    = 5'd4;
    localparam logic [4:0] S_ID    = 5'd5;
    localparam logic [4:0] S_IQ    = 5'd6;
    localparam logic [4:0] S_DRV   = 5'd7;
    localparam logic [4:0] S_VA    = 5'd8;
    localparam logic [4:0] S_VB    = 5'd9;
    localparam logic [4:0] S_CA    = 5'd10;
    localparam logic [4:0] S_CB    = 5'd11;
    localparam logic [4:0] S_SN    = 5'd12;
    localparam logic [4:0] S_CS    = 5'd13;
    localparam logic [4:0] S_MD    = 5'd14;
    localparam logic [4:0] S_MQ    = 5'd15;
    localparam logic [4:0] S_W     = 5'd16;
    localparam logic [4:0] S_INTEG = 5'd17;
    localparam logic [4:0] S_RS    = 5'd18;
    localparam logic [4:0] S_LD    = 5'd19;
    localparam logic [4:0] S_LQ    = 5'd20;
    localparam logic [4:0] S_ILD   = 5'd21;
    localparam logic [4:0] S_ILQ   = 5'd22;
    localparam logic [4:0] S_FLUX  = 5'd23;
    localparam logic [4:0] S_KP    = 5'd24;
    localparam logic [4:0] S_KI    = 5'd25;
    localparam logic [4:0] S_PER   = 5'd26;
    localparam logic [4:0] S_INVTP = 5'd27;

    localparam logic [PC_W-1:0] CLR_ADDR  = 7'd93;
    localparam logic [PC_W-1:0] PROG_LAST = 7'd94;

    typedef struct packed {
        logic [3:0]      op;
        logic [4:0]      a;
        logic [4:0]      b;
        logic [4:0]      dst;
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t uw(input logic [3:0] op, input logic [4:0] a,
                                  input logic [4:0] b, input logic [4:0] dst);
        uword_t w;
        w.op = op;
        w.a = a;
        w.b = b;
        w.dst = dst;
        w.target = CLR_ADDR;
        return w;
    endfunction

    // Observer program: reference frame, d then q model, adaptation, angle
    function automatic uword_t prog_word(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            7'd0:  w = uw(OP_JCLR, S_ZERO, S_ZERO, S_ZERO);
            7'd1:  w = uw(OP_SIN,  S_ZERO, S_ZERO, S_ZERO);
            7'd2:  w = uw(OP_COS,  S_ZERO, S_ZERO, S_ZERO);
            7'd3:  w = uw(OP_MUL,  S_VA, S_CS, S_ZERO);
            7'd4:  w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd5:  w = uw(OP_MUL,  S_VB, S_SN, S_ZERO);
            7'd6:  w = uw(OP_WB,   S_ZERO, S_ZERO, S_Y);
            7'd7:  w = uw(OP_ADD,  S_X, S_Y, S_UD);
            7'd8:  w = uw(OP_MUL,  S_VB, S_CS, S_ZERO);
            7'd9:  w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd10: w = uw(OP_MUL,  S_VA, S_SN, S_ZERO);
            7'd11: w = uw(OP_WB,   S_ZERO, S_ZERO, S_Y);
            7'd12: w = uw(OP_SUB,  S_X, S_Y, S_UQ);
            7'd13: w = uw(OP_MUL,  S_RS, S_FLUX, S_ZERO);
            7'd14: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd15: w = uw(OP_MUL,  S_X, S_ILD, S_ZERO);
            7'd16: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd17: w = uw(OP_ADD,  S_UD, S_X, S_UD);
            7'd18: w = uw(OP_MUL,  S_CA, S_CS, S_ZERO);
            7'd19: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd20: w = uw(OP_MUL,  S_CB, S_SN, S_ZERO);
            7'd21: w = uw(OP_WB,   S_ZERO, S_ZERO, S_Y);
            7'd22: w = uw(OP_ADD,  S_X, S_Y, S_ID);
            7'd23: w = uw(OP_MUL,  S_CB, S_CS, S_ZERO);
            7'd24: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd25: w = uw(OP_MUL,  S_CA, S_SN, S_ZERO);
            7'd26: w = uw(OP_WB,   S_ZERO, S_ZERO, S_Y);
            7'd27: w = uw(OP_SUB,  S_X, S_Y, S_IQ);
            7'd28: w = uw(OP_MUL,  S_FLUX, S_ILD, S_ZERO);
            7'd29: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd30: w = uw(OP_ADD,  S_ID, S_X, S_ID);
            7'd31: w = uw(OP_MUL,  S_RS, S_MD, S_ZERO);
            7'd32: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd33: w = uw(OP_MUL,  S_X, S_ILD, S_ZERO);
            7'd34: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd35: w = uw(OP_SUB,  S_ZERO, S_X, S_DRV);
            7'd36: w = uw(OP_MUL,  S_W, S_MQ, S_ZERO);
            7'd37: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd38: w = uw(OP_MUL,  S_X, S_LQ, S_ZERO);
            7'd39: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd40: w = uw(OP_MUL,  S_X, S_ILD, S_ZERO);
            7'd41: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd42: w = uw(OP_ADD,  S_DRV, S_X, S_DRV);
            7'd43: w = uw(OP_MUL,  S_UD, S_ILD, S_ZERO);
            7'd44: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd45: w = uw(OP_ADD,  S_DRV, S_X, S_DRV);
            7'd46: w = uw(OP_MULT, S_DRV, S_PER, S_ZERO);
            7'd47: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd48: w = uw(OP_ADD,  S_MD, S_X, S_MD);
            7'd49: w = uw(OP_MUL,  S_RS, S_MQ, S_ZERO);
            7'd50: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd51: w = uw(OP_MUL,  S_X, S_ILQ, S_ZERO);
            7'd52: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd53: w = uw(OP_SUB,  S_ZERO, S_X, S_DRV);
            7'd54: w = uw(OP_MUL,  S_W, S_MD, S_ZERO);
            7'd55: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd56: w = uw(OP_MUL,  S_X, S_LD, S_ZERO);
            7'd57: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd58: w = uw(OP_MUL,  S_X, S_ILQ, S_ZERO);
            7'd59: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd60: w = uw(OP_SUB,  S_DRV, S_X, S_DRV);
            7'd61: w = uw(OP_MUL,  S_UQ, S_ILQ, S_ZERO);
            7'd62: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd63: w = uw(OP_ADD,  S_DRV, S_X, S_DRV);
            7'd64: w = uw(OP_MULT, S_DRV, S_PER, S_ZERO);
            7'd65: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd66: w = uw(OP_ADD,  S_MQ, S_X, S_MQ);
            7'd67: w = uw(OP_SUB,  S_ID, S_MD, S_X);
            7'd68: w = uw(OP_MUL,  S_X, S_MQ, S_ZERO);
            7'd69: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd70: w = uw(OP_MUL,  S_X, S_LQ, S_ZERO);
            7'd71: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd72: w = uw(OP_MUL,  S_X, S_ILD, S_ZERO);
            7'd73: w = uw(OP_WB,   S_ZERO, S_ZERO, S_UD);
            7'd74: w = uw(OP_SUB,  S_IQ, S_MQ, S_X);
            7'd75: w = uw(OP_MUL,  S_X, S_MD, S_ZERO);
            7'd76: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd77: w = uw(OP_MUL,  S_X, S_LD, S_ZERO);
            7'd78: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd79: w = uw(OP_MUL,  S_X, S_ILQ, S_ZERO);
            7'd80: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd81: w = uw(OP_SUB,  S_UD, S_X, S_DRV);
            7'd82: w = uw(OP_MUL,  S_KI, S_DRV, S_ZERO);
            7'd83: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd84: w = uw(OP_ADD,  S_INTEG, S_X, S_INTEG);
            7'd85: w = uw(OP_MUL,  S_KP, S_DRV, S_ZERO);
            7'd86: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd87: w = uw(OP_ADD,  S_X, S_INTEG, S_W);
            7'd88: w = uw(OP_MULT, S_W, S_PER, S_ZERO);
            7'd89: w = uw(OP_WB,   S_ZERO, S_ZERO, S_X);
            7'd90: w = uw(OP_MULT, S_X, S_INVTP, S_ZERO);
            7'd91: w = uw(OP_ANG,  S_ZERO, S_ZERO, S_ZERO);
            7'd92: w = uw(OP_END,  S_ZERO, S_ZERO, S_ZERO);
            7'd93: w = uw(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            default: w = uw(OP_END, S_ZERO, S_ZERO, S_ZERO);
        endcase
        return w;
    endfunction

    // First-quadrant sine magnitude, Taylor series in Q2.30, rounded to Q16.16
    function automatic logic [MAG_W-1:0] sine_mag(input int r, input int tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x = (64'(r) * TWO_PI_Q30) >> tb;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        t = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s = (x * t) >> 30;
        s = (s + 64'd8192) >> 14;
        if (s > 64'd65536)
        begin
            s = 64'd65536;
        end
        return s[MAG_W-1:0];
    endfunction

    // Clip detection and saturated value of a widened result
    function automatic logic sat_clip(input logic signed [PROD_W-1:0] v);
        return v[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){v[DATA_W-1]}};
    endfunction

    function automatic logic [DATA_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
        if (!sat_clip(v))
        begin
            return v[DATA_W-1:0];
        end
        return v[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

endpackage

### sv/mras_sine_lut.sv
`timescale 1ns / 1ps

module mras_sine_lut
    import mras_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
)
(
    input  logic [ANGLE_W-1:0] angle,
    input  logic               cos_sel,
    output logic [DATA_W-1:0]  value
);

    localparam int N_ENTRIES = 1 << SINE_TABLE_BITS;
    localparam int QUARTER   = N_ENTRIES / 4;
    localparam int R_W       = SINE_TABLE_BITS - 1;

    logic [MAG_W-1:0]           quarter_tab [QUARTER+1];
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [R_W-1:0]             r;
    logic [MAG_W-1:0]           mag;

    // Quarter-wave table, folded to constants at elaboration
    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_tab
        localparam logic [MAG_W-1:0] ENTRY = sine_mag(g, SINE_TABLE_BITS);
        assign quarter_tab[g] = ENTRY;
    end

    // Fold the angle into the first quadrant and restore the sign
    always_comb
    begin
        idx = angle[ANGLE_W-1 -: SINE_TABLE_BITS];
        if (cos_sel)
        begin
            idx = idx + SINE_TABLE_BITS'(QUARTER);
        end
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r = {1'b0, idx[SINE_TABLE_BITS-3:0]};
        if (quad[0])
        begin
            r = R_W'(QUARTER) - r;
        end
        mag = quarter_tab[r];
        value = quad[1] ? -DATA_W'(mag) : DATA_W'(mag);
    end

endmodule

### sv/mras_speed_observer_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_ready   | func, volt_alpha, volt_beta, curr_alpha, curr_beta
// out      | output    | out_valid / out_ready | speed_est, angle_est, saturated
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An estimation step runs 93 words of the microprogram on one 33x33 multiplier
// and one saturating adder; a clear command runs only the jump word, the clear
// word and the end word. A new sample is taken only while no step is running.
// The multiplier result is registered, so every product costs two program
// steps. Reset is asynchronous, active low, and restores the register defaults
// and zero state. A result waiting on out_ready holds the sequencer at its last
// step; a new sample is taken once it leaves.

module mras_speed_observer_unit
    import mras_pkg::*;
#(
    parameter logic [31:0] SAMPLE_PERIOD_Q32 = SAMPLE_PERIOD_DEF,
    parameter int          SINE_TABLE_BITS   = SINE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] volt_alpha,
    input  logic signed [DATA_W-1:0] volt_beta,
    input  logic signed [DATA_W-1:0] curr_alpha,
    input  logic signed [DATA_W-1:0] curr_beta,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] speed_est,
    output logic [ANGLE_W-1:0]       angle_est,
    output logic                     saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    logic [CFG_W-1:0]         cfg_reg [REG_COUNT];
    logic                     busy_reg, busy_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     sat_reg;
    logic                     func_reg;
    logic [DATA_W-1:0]        va_reg, vb_reg, ca_reg, cb_reg;
    logic [DATA_W-1:0]        x_reg, y_reg, ud_reg, uq_reg, id_reg, iq_reg, drv_reg;
    logic [DATA_W-1:0]        sn_reg, cs_reg;
    logic [DATA_W-1:0]        md_reg, mq_reg, w_reg, integ_reg;
    logic [ANGLE_W-1:0]       angle_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     sh32_reg;
    logic [DATA_W-1:0]        speed_out_reg;
    logic [ANGLE_W-1:0]       angle_out_reg;
    logic                     sat_out_reg;

    uword_t                   uword;
    logic signed [OPND_W-1:0] opa, opb;
    logic signed [PROD_W-1:0] shifted, alu_wide;
    logic [DATA_W-1:0]        res;
    logic                     res_clip;
    logic                     res_write;
    logic [DATA_W-1:0]        trig;
    logic                     take_in, deliver;

    assign uword    = prog_word(pc_reg);
    assign in_ready = !busy_reg;
    assign take_in  = in_valid && !busy_reg;
    assign deliver  = busy_reg && (uword.op == OP_END) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign speed_est = speed_out_reg;
    assign angle_est = angle_out_reg;
    assign saturated = sat_out_reg;

    mras_sine_lut #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine (
        .angle  (angle_reg),
        .cos_sel(uword.op == OP_COS),
        .value  (trig)
    );

    // Select an operand from the working set
    function automatic logic signed [OPND_W-1:0] pick(input logic [4:0] code,
        input logic [DATA_W-1:0] xv, yv, udv, uqv, idv, iqv, drvv, vav, vbv, cav, cbv,
        input logic [DATA_W-1:0] snv, csv, mdv, mqv, wv, intv,
        input logic [CFG_W-1:0] rs, ld, lq, ild, ilq, fl, kp, ki);
        logic signed [OPND_W-1:0] v;
        case (code)
            S_X:     v = OPND_W'($signed(xv));
            S_Y:     v = OPND_W'($signed(yv));
            S_UD:    v = OPND_W'($signed(udv));
            S_UQ:    v = OPND_W'($signed(uqv));
            S_ID:    v = OPND_W'($signed(idv));
            S_IQ:    v = OPND_W'($signed(iqv));
            S_DRV:   v = OPND_W'($signed(drvv));
            S_VA:    v = OPND_W'($signed(vav));
            S_VB:    v = OPND_W'($signed(vbv));
            S_CA:    v = OPND_W'($signed(cav));
            S_CB:    v = OPND_W'($signed(cbv));
            S_SN:    v = OPND_W'($signed(snv));
            S_CS:    v = OPND_W'($signed(csv));
            S_MD:    v = OPND_W'($signed(mdv));
            S_MQ:    v = OPND_W'($signed(mqv));
            S_W:     v = OPND_W'($signed(wv));
            S_INTEG: v = OPND_W'($signed(intv));
            S_RS:    v = {2'b00, rs};
            S_LD:    v = {2'b00, ld};
            S_LQ:    v = {2'b00, lq};
            S_ILD:   v = {2'b00, ild};
            S_ILQ:   v = {2'b00, ilq};
            S_FLUX:  v = {2'b00, fl};
            S_KP:    v = {2'b00, kp};
            S_KI:    v = {2'b00, ki};
            S_PER:   v = {1'b0, SAMPLE_PERIOD_Q32};
            S_INVTP: v = {1'b0, INV_TWO_PI_Q32};
            default: v = '0;
        endcase
        return v;
    endfunction

    // Operand fetch, floor shift of the product and saturating add or subtract
    always_comb
    begin
        opa = pick(uword.a, x_reg, y_reg, ud_reg, uq_reg, id_reg, iq_reg, drv_reg,
                   va_reg, vb_reg, ca_reg, cb_reg, sn_reg, cs_reg, md_reg, mq_reg,
                   w_reg, integ_reg, cfg_reg[REG_RS], cfg_reg[REG_LD], cfg_reg[REG_LQ],
                   cfg_reg[REG_ILD], cfg_reg[REG_ILQ], cfg_reg[REG_FLUX],
                   cfg_reg[REG_KP], cfg_reg[REG_KI]);
        opb = pick(uword.b, x_reg, y_reg, ud_reg, uq_reg, id_reg, iq_reg, drv_reg,
                   va_reg, vb_reg, ca_reg, cb_reg, sn_reg, cs_reg, md_reg, mq_reg,
                   w_reg, integ_reg, cfg_reg[REG_RS], cfg_reg[REG_LD], cfg_reg[REG_LQ],
                   cfg_reg[REG_ILD], cfg_reg[REG_ILQ], cfg_reg[REG_FLUX],
                   cfg_reg[REG_KP], cfg_reg[REG_KI]);
        shifted = sh32_reg ? (prod_reg >>> 32) : (prod_reg >>> 16);
        if (uword.op == OP_SUB)
        begin
            alu_wide = PROD_W'(opa) - PROD_W'(opb);
        end
        else
        begin
            alu_wide = PROD_W'(opa) + PROD_W'(opb);
        end
        if (uword.op == OP_WB)
        begin
            alu_wide = shifted;
        end
        res = sat_val(alu_wide);
        res_clip = sat_clip(alu_wide);
        res_write = busy_reg && ((uword.op == OP_WB) || (uword.op == OP_ADD)
                                 || (uword.op == OP_SUB));
    end

    // Sequencer: advance the step counter, jump on a clear command, hold at the end
    always_comb
    begin
        busy_next = busy_reg;
        pc_next = pc_reg;
        if (take_in)
        begin
            busy_next = 1'b1;
            pc_next = '0;
        end
        else if (busy_reg)
        begin
            case (uword.op)
                OP_JCLR:
                begin
                    pc_next = func_reg ? uword.target : pc_reg + 1'b1;
                end
                OP_END:
                begin
                    if (deliver)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    pc_next = pc_reg + 1'b1;
                end
            endcase
        end
        out_valid_next = out_valid_reg;
        if (deliver)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[REG_KP] <= KP_RESET;
            cfg_reg[REG_KI] <= KI_RESET;
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT)))
        begin
            cfg_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Observer state and clip flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg <= '0;
            mq_reg <= '0;
            w_reg <= '0;
            integ_reg <= '0;
            angle_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (take_in)
        begin
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (res_write && res_clip)
            begin
                sat_reg <= 1'b1;
            end
            if (res_write)
            begin
                case (uword.dst)
                    S_MD:    md_reg <= res;
                    S_MQ:    mq_reg <= res;
                    S_W:     w_reg <= res;
                    S_INTEG: integ_reg <= res;
                    default: ;
                endcase
            end
            if (uword.op == OP_ANG)
            begin
                angle_reg <= angle_reg + shifted[ANGLE_W-1:0];
            end
            if (uword.op == OP_CLR)
            begin
                md_reg <= '0;
                mq_reg <= '0;
                w_reg <= '0;
                integ_reg <= '0;
                angle_reg <= '0;
            end
        end
    end

    // Sample capture, scratch registers, product register and result register
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            func_reg <= func;
            va_reg <= volt_alpha;
            vb_reg <= volt_beta;
            ca_reg <= curr_alpha;
            cb_reg <= curr_beta;
        end
        if (busy_reg)
        begin
            if (res_write)
            begin
                case (uword.dst)
                    S_X:     x_reg <= res;
                    S_Y:     y_reg <= res;
                    S_UD:    ud_reg <= res;
                    S_UQ:    uq_reg <= res;
                    S_ID:    id_reg <= res;
                    S_IQ:    iq_reg <= res;
                    S_DRV:   drv_reg <= res;
                    default: ;
                endcase
            end
            if (uword.op == OP_SIN)
            begin
                sn_reg <= trig;
            end
            if (uword.op == OP_COS)
            begin
                cs_reg <= trig;
            end
            if ((uword.op == OP_MUL) || (uword.op == OP_MULT))
            begin
                prod_reg <= opa * opb;
                sh32_reg <= (uword.op == OP_MULT);
            end
        end
        if (deliver)
        begin
            speed_out_reg <= w_reg;
            angle_out_reg <= angle_reg;
            sat_out_reg <= sat_reg;
        end
    end

    ap_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg && (pc_reg == '0))
        else $error("transfer did not start the program");

    ap_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $fell(busy_reg))
        else $error("result raised without finishing the program");

    ap_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= PROG_LAST)
        else $error("step counter left the program");

    ap_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (uword.op == OP_CLR) |=> (w_reg == '0) && (angle_reg == '0)
                                              && !sat_reg)
        else $error("clear left state behind");

endmodule
